FILE: rtl/core/sma_pkg.sv
// Shared types and constants of the moving average filter.
package sma_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_BITS   = 7;
  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int COUNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int TOTAL_BITS = SAMPLE_BITS + SLOT_BITS + 1;
  localparam int FRAC_BITS  = 8;
  localparam int AVG_BITS   = 24;
  localparam int DIV_BITS   = TOTAL_BITS + FRAC_BITS;
  localparam int STEP_BITS  = $clog2(DIV_BITS);
  localparam int OUT_BITS   = ((AVG_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(5);

  // quotient magnitude limits of the signed result
  localparam logic [DIV_BITS-1:0] AVG_MAG_POS = DIV_BITS'((64'd1 << (AVG_BITS - 1)) - 64'd1);
  localparam logic [DIV_BITS-1:0] AVG_MAG_NEG = DIV_BITS'(64'd1 << (AVG_BITS - 1));

  typedef struct packed {
    logic signed [TOTAL_BITS-1:0] total;
    logic [COUNT_BITS-1:0]        count;
  } q_entry_t;

endpackage

FILE: rtl/core/sliding_moving_average.sv
// Moving average of the last window_size signed samples, mean in Q8 fixed point.
// The front end reads the oldest sample from the ring RAM and then updates the
// running total; the back end loads the queue entry, runs a bit-serial restoring
// divider of 31 steps and then moves the result into the output register.
// A two-entry queue sits between them, so the next sample is taken while a division
// runs and a result waits in the output register. Writing window_size (0 reads as 1,
// values above 64 as 64) clears the history; write it only while the block is idle.
module sliding_moving_average (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sma_pkg::SAMPLE_BITS-1:0] in_tdata,   // [15:0] sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sma_pkg::OUT_BITS-1:0]   out_tdata,  // [23:0] average_q8, [30:24] held_count
  input  logic                           cfg_wr_en,
  input  logic [sma_pkg::CFG_BITS-1:0]   cfg_wr_data
);
  import sma_pkg::*;

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_in, q_out;

  sma_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_push      (q_push),
    .q_data      (q_in),
    .q_full      (q_full)
  );

  sma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sma_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: rtl/core/sma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/sma_front.sv
// Front end: takes samples, keeps the sample ring, running total and fill count.
module sma_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sma_pkg::SAMPLE_BITS-1:0] in_tdata,
  input  logic                          cfg_wr_en,
  input  logic [sma_pkg::CFG_BITS-1:0]  cfg_wr_data,
  output logic                          q_push,
  output sma_pkg::q_entry_t             q_data,
  input  logic                          q_full
);
  import sma_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  front_state_t state_r, state_nxt;
  logic [SLOT_BITS-1:0]          slot_r, slot_nxt;
  logic [COUNT_BITS-1:0]         fill_r, fill_nxt;
  logic [COUNT_BITS-1:0]         window_r, window_nxt;
  logic signed [TOTAL_BITS-1:0]  total_r, total_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;

  logic                   accept;
  logic                   drop;
  logic                   rd_en;
  logic [SLOT_BITS-1:0]   rd_addr;
  logic [SAMPLE_BITS-1:0] old_raw;
  logic [COUNT_BITS:0]    slot_ext;
  logic [COUNT_BITS:0]    win_ext;

  assign in_tready = (state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign drop      = (fill_r >= window_r);
  assign q_push    = (state_r == F_UPD) && !q_full;
  assign rd_en     = accept;

  // oldest slot: (slot - window) mod MAX_WINDOW
  assign slot_ext = (COUNT_BITS + 1)'(slot_r);
  assign win_ext  = (COUNT_BITS + 1)'(window_r);
  always_comb begin
    if (slot_ext >= win_ext) begin
      rd_addr = SLOT_BITS'(slot_ext - win_ext);
    end else begin
      rd_addr = SLOT_BITS'(slot_ext + (COUNT_BITS + 1)'(MAX_WINDOW) - win_ext);
    end
  end

  sma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (q_push),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (old_raw)
  );

  always_comb begin
    total_nxt = total_r + TOTAL_BITS'(sample_r);
    if (drop) begin
      total_nxt = total_nxt - TOTAL_BITS'($signed(old_raw));
    end
  end

  assign q_data.total = total_nxt;
  assign q_data.count = drop ? fill_r : fill_r + COUNT_BITS'(1);

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    fill_nxt   = fill_r;
    window_nxt = window_r;
    priority if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        window_nxt = COUNT_BITS'(1);
      end else if (32'(cfg_wr_data) > MAX_WINDOW) begin
        window_nxt = COUNT_BITS'(MAX_WINDOW);
      end else begin
        window_nxt = COUNT_BITS'(cfg_wr_data);
      end
      slot_nxt = '0;
      fill_nxt = '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_nxt = F_UPD;
          end
        end
        F_UPD: begin
          if (q_push) begin
            state_nxt = F_IDLE;
            fill_nxt  = q_data.count;
            slot_nxt  = (32'(slot_r) == MAX_WINDOW - 1) ? '0 : slot_r + SLOT_BITS'(1);
          end
        end
        default: state_nxt = F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      slot_r   <= '0;
      fill_r   <= '0;
      window_r <= WINDOW_RESET;
      total_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      slot_r   <= slot_nxt;
      fill_r   <= fill_nxt;
      window_r <= window_nxt;
      if (cfg_wr_en) begin
        total_r <= '0;
      end else if (q_push) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_tdata;
    end
  end

endmodule

FILE: rtl/core/sma_queue.sv
// Small FIFO between the front end and the divider.
module sma_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sma_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output sma_pkg::q_entry_t pop_data,
  output logic              empty
);
  import sma_pkg::*;

  q_entry_t                entry_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_BITS:0]     level_r;

  assign full     = (32'(level_r) == Q_DEPTH);
  assign empty    = (level_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + Q_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + Q_PTR_BITS'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + (Q_PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
        level_r <= level_r - (Q_PTR_BITS + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/sma_back.sv
// Back end: bit-serial signed division of total*256 by count, output register.
module sma_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  sma_pkg::q_entry_t           q_data,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sma_pkg::OUT_BITS-1:0] out_tdata
);
  import sma_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [STEP_BITS-1:0]  step_r;
  logic [DIV_BITS-1:0]   quo_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS-1:0] divisor_r;
  logic                  neg_r;
  logic                  out_valid_r;
  logic [OUT_BITS-1:0]   out_data_r;

  logic [TOTAL_BITS:0]   total_ext;
  logic [TOTAL_BITS:0]   total_mag;
  logic [COUNT_BITS:0]   rem_shift;
  logic                  fits;
  logic                  out_free;
  logic [DIV_BITS-1:0]   mag_sat;
  logic [AVG_BITS-1:0]   avg;

  assign total_ext = (TOTAL_BITS + 1)'(q_data.total);
  assign total_mag = q_data.total[TOTAL_BITS-1] ? -total_ext : total_ext;
  assign rem_shift = {rem_r, quo_r[DIV_BITS-1]};
  assign fits      = (rem_shift >= {1'b0, divisor_r});
  assign out_free  = !out_valid_r || out_tready;
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    if (neg_r) begin
      mag_sat = (quo_r > AVG_MAG_NEG) ? AVG_MAG_NEG : quo_r;
      avg     = -AVG_BITS'(mag_sat);
    end else begin
      mag_sat = (quo_r > AVG_MAG_POS) ? AVG_MAG_POS : quo_r;
      avg     = AVG_BITS'(mag_sat);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (q_pop) state_nxt = B_DIV;
      B_DIV: begin
        if (32'(step_r) == DIV_BITS - 1) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quo_r     <= DIV_BITS'(total_mag) << FRAC_BITS;
      rem_r     <= '0;
      divisor_r <= q_data.count;
      neg_r     <= q_data.total[TOTAL_BITS-1];
      step_r    <= '0;
    end else if (state_r == B_DIV) begin
      rem_r  <= fits ? COUNT_BITS'(rem_shift - {1'b0, divisor_r}) : COUNT_BITS'(rem_shift);
      quo_r  <= {quo_r[DIV_BITS-2:0], fits};
      step_r <= step_r + STEP_BITS'(1);
    end
    if (state_r == B_OUT && out_free) begin
      out_data_r <= OUT_BITS'({divisor_r, avg});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/sma_checker.sv
// Port-level checks of the moving average filter, bound to the top level.
module sma_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [sma_pkg::SAMPLE_BITS-1:0] in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sma_pkg::OUT_BITS-1:0]   out_tdata
);
  import sma_pkg::*;

  logic [COUNT_BITS-1:0] held;
  assign held = out_tdata[AVG_BITS +: COUNT_BITS];

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input beat withdrawn or changed while stalled");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> held != '0)
    else $error("held_count is zero");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(held) <= MAX_WINDOW)
    else $error("held_count above window limit");

endmodule

bind sliding_moving_average sma_checker u_sma_checker (.*);
